/* hdl/base64_stream_encoder_unit_assert.svh */
// Assertion macros used by the base64 stream encoder top module.
`ifndef BASE64_STREAM_ENCODER_UNIT_ASSERT_SVH
`define BASE64_STREAM_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define B64SE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("b64se assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define B64SE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("b64se assertion failed");

`endif

/* hdl/b64se_pkg.sv */
// Types, constants and the alphabet lookup for the base64 stream encoder.
`timescale 1ns / 1ps
package b64se_pkg;

	localparam logic [6:0] PAD_CHAR = 7'h3D;

	// One complete or padded group handed from the front to the back.
	typedef struct packed {
		logic [23:0] bytes;   // first byte in the top bits, missing bytes zero
		logic [1:0]  nbytes;  // 1 to 3 real bytes
		logic        last;    // group closes a message
	} b64se_grp_t;

	typedef struct packed {
		logic full;
		logic empty;
	} b64se_qstat_t;

	function automatic logic [6:0] b64se_char(input logic [5:0] sextet);
		logic [6:0] v;
		v = {1'b0, sextet};
		if (sextet < 6'd26)
			return 7'd65 + v;
		else if (sextet < 6'd52)
			return 7'd71 + v;          // 'a' - 26
		else if (sextet < 6'd62)
			return v - 7'd4;           // '0' - 52
		else if (sextet == 6'd62)
			return 7'd43;              // '+'
		else
			return 7'd47;              // '/'
	endfunction

endpackage

/* hdl/base64_stream_encoder_unit.sv */
// Flow: a group's closing byte pushes it into the queue; the back end loads it and registers its first character.
// Throughput: one input byte per cycle while the queue has room, one character per cycle out
// while the receiver is ready; a group of three bytes yields four characters, so sustained input
// is limited by the single character serializer in the back end.
// Reset: arst_n clears the held-byte count, the group queue, the serializer state and the output valid flag.
`timescale 1ns / 1ps
module base64_stream_encoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
	output logic       m_axis_tlast
);
	import b64se_pkg::*;

`include "base64_stream_encoder_unit_assert.svh"

	b64se_grp_t   wr_grp, rd_grp;
	b64se_qstat_t qstat;
	logic         push, pop;
	logic [1:0]   held_cnt;

	b64se_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.qstat         (qstat),
		.push          (push),
		.grp           (wr_grp),
		.held_cnt      (held_cnt)
	);

	b64se_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_grp (wr_grp),
		.pop    (pop),
		.rd_grp (rd_grp),
		.qstat  (qstat)
	);

	b64se_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd_grp        (rd_grp),
		.qstat         (qstat),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	`B64SE_ASSERT_NOW(a_no_push_full, push, !qstat.full)
	`B64SE_ASSERT_NOW(a_no_pop_empty, pop, !qstat.empty)
	`B64SE_ASSERT_NOW(a_held_cnt_range, 1'b1, held_cnt != 2'd3)
	`B64SE_ASSERT_NEXT(a_last_clears, s_axis_tvalid && s_axis_tready && s_axis_tlast,
		held_cnt == 2'd0)

endmodule

/* hdl/b64se_front.sv */
// Front end: accepts bytes, gathers them into groups of up to three (closing a group early at tlast) and pushes groups.
`timescale 1ns / 1ps
module b64se_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // [7:0] in_byte
	input  logic                  s_axis_tlast,
	input  b64se_pkg::b64se_qstat_t qstat,
	output logic                  push,
	output b64se_pkg::b64se_grp_t grp,
	output logic [1:0]            held_cnt
);
	import b64se_pkg::*;

	logic [1:0] cnt_q;
	logic [7:0] held_q [2];
	logic       accept;
	logic       emit;
	logic [7:0] g0, g1, g2;

	assign s_axis_tready = !qstat.full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign emit          = (cnt_q == 2'd2) || s_axis_tlast;
	assign push          = accept && emit;
	assign held_cnt      = cnt_q;

	always_comb begin
		g0 = held_q[0];
		g1 = 8'd0;
		g2 = 8'd0;
		case (cnt_q)
			2'd0: begin
				g0 = s_axis_tdata;
			end
			2'd1: begin
				g1 = s_axis_tdata;
			end
			default: begin
				g1 = held_q[1];
				g2 = s_axis_tdata;
			end
		endcase
	end

	assign grp.bytes  = {g0, g1, g2};
	assign grp.nbytes = (cnt_q == 2'd0) ? 2'd1 : ((cnt_q == 2'd1) ? 2'd2 : 2'd3);
	assign grp.last   = s_axis_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= emit ? 2'd0 : cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !emit) begin
			held_q[cnt_q[0]] <= s_axis_tdata;
		end
	end

endmodule

/* hdl/b64se_queue.sv */
// Short group queue that decouples the front end from the character serializer.
`timescale 1ns / 1ps
module b64se_queue #(
	parameter int DEPTH = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  b64se_pkg::b64se_grp_t   wr_grp,
	input  logic                    pop,
	output b64se_pkg::b64se_grp_t   rd_grp,
	output b64se_pkg::b64se_qstat_t qstat
);
	import b64se_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	b64se_grp_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign rd_grp      = mem_q[rd_ptr_q];
	assign qstat.full  = (cnt_q == FULL_CNT);
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_grp;
		end
	end

endmodule

/* hdl/b64se_back.sv */
// Back end: splits each group into four characters and drives the output register.
`timescale 1ns / 1ps
module b64se_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  b64se_pkg::b64se_grp_t   rd_grp,
	input  b64se_pkg::b64se_qstat_t qstat,
	output logic                    pop,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [7:0]              m_axis_tdata,   // [6:0] out_char, [7] zero
	output logic                    m_axis_tlast
);
	import b64se_pkg::*;

	b64se_grp_t cur_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [6:0] out_char_q;
	logic       out_last_q;
	logic       advance;
	logic [5:0] sextet;
	logic [6:0] chr;

	assign advance = !out_valid_q || m_axis_tready;
	assign pop     = !qstat.empty && (!busy_q || (advance && idx_q == 2'd3));

	always_comb begin
		case (idx_q)
			2'd0:    sextet = cur_q.bytes[23:18];
			2'd1:    sextet = cur_q.bytes[17:12];
			2'd2:    sextet = cur_q.bytes[11:6];
			default: sextet = cur_q.bytes[5:0];
		endcase
	end

	// Positions past the real byte count plus one become padding.
	assign chr = (idx_q > cur_q.nbytes) ? PAD_CHAR : b64se_char(sextet);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			// A new group is loaded either into an idle serializer or right behind
			// the fourth character of the current one.
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (advance && busy_q) begin
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && busy_q) begin
			out_char_q <= chr;
			out_last_q <= cur_q.last && (idx_q == 2'd3);
		end
		if (pop) begin
			cur_q <= rd_grp;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_char_q};
	assign m_axis_tlast  = out_last_q;

endmodule

/* bench/tb_base64_stream_encoder_unit.sv */
// Self-checking testbench for the base64 stream encoder with random flow control.
`timescale 1ns / 1ps
module tb_base64_stream_encoder_unit;
	import b64se_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 200;
	localparam int RANDOM_ITEMS   = 115;

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} enc_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	// Predictor state: bytes of the group still open and how many there are.
	logic [7:0] open_bytes [2];
	logic [1:0] open_count;
	string      b64_alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	enc_char_t  pending_chars [$];
	int         fail_count = 0;
	int         burst_left = 0;
	int         idle_cycles = 0;
	logic       hold_req = 1'b0;
	logic       hold_ack = 1'b0;
	int         bytes_sent = 0;

	base64_stream_encoder_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Updates the open group with one accepted byte and queues the characters it releases.
	function automatic void encode_byte(input logic [7:0] b, input logic is_last);
		logic [7:0] grp [3];
		logic [5:0] sx [4];
		int         cnt;
		enc_char_t  c;
		cnt = (open_count > 2'd2) ? 2 : int'(open_count);
		if (cnt < 2 && !is_last) begin
			open_bytes[cnt] = b;
			open_count = 2'(cnt + 1);
			return;
		end
		grp[0] = 8'h00;
		grp[1] = 8'h00;
		grp[2] = 8'h00;
		for (int k = 0; k < cnt; k++)
			grp[k] = open_bytes[k];
		grp[cnt] = b;
		sx[0] = grp[0][7:2];
		sx[1] = {grp[0][1:0], grp[1][7:4]};
		sx[2] = {grp[1][3:0], grp[2][7:6]};
		sx[3] = grp[2][5:0];
		for (int k = 0; k < 4; k++) begin
			c.ch = (k <= cnt + 1) ? 7'(b64_alphabet[sx[k]]) : PAD_CHAR;
			c.last = is_last && (k == 3);
			pending_chars.push_back(c);
		end
		open_count = 2'd0;
	endfunction

	// Offers one byte, with random gaps between bursts, and waits for it to be taken.
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= is_last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		encode_byte(b, is_last);
		bytes_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_message(input int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 7))
				0: b = 8'h00;
				1: b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			send_byte(b, i == len - 1);
		end
	endtask

	// Padding with one and two bytes, full groups, the all-zero, all-one and '+' groups.
	task automatic test_directed();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b1);
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6E, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFB, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBE, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'h83, 1'b0);
		send_byte(8'h80, 1'b1);
		wait_drained();
	endtask

	// The receiver holds off while bytes keep coming, so the block must stall its input.
	task automatic test_output_stall();
		hold_req <= ~hold_req;
		burst_left = 30;
		repeat (4) send_message(6);
		send_message(5);
		wait_drained();
	endtask

	task automatic test_random_messages();
		int target;
		target = bytes_sent + RANDOM_ITEMS;
		while (bytes_sent < target) begin
			if ($urandom_range(0, 4) == 0)
				send_message($urandom_range(10, 30));
			else
				send_message($urandom_range(1, 9));
		end
		wait_drained();
	endtask

	// Receiver: a ready pattern picked at random from four modes, plus one long hold on request.
	initial begin
		int cyc;
		int mode;
		cyc = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= (cyc % 3 != 0);
					default: m_axis_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// Compares every accepted character with the oldest one still owed.
	always @(posedge clk) begin
		enc_char_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected word: char %h last %b", m_axis_tdata[6:0], m_axis_tlast);
				fail_count++;
			end else begin
				want = pending_chars.pop_front();
				if (m_axis_tdata[6:0] !== want.ch) begin
					$error("out_char: expected %h, actual %h", want.ch, m_axis_tdata[6:0]);
					fail_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("out_last: expected %b, actual %b", want.last, m_axis_tlast);
					fail_count++;
				end
				if (m_axis_tdata[7] !== 1'b0) begin
					$error("tdata bit 7: expected 0, actual %b", m_axis_tdata[7]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("base64_stream_encoder_unit: mismatch");
				$finish;
			end
		end
	end

	initial begin
		open_bytes[0] = 8'h00;
		open_bytes[1] = 8'h00;
		open_count = 2'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_output_stall();
		test_random_messages();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_chars.size() == 0)
			$display("base64_stream_encoder_unit: match");
		else
			$display("base64_stream_encoder_unit: mismatch");
		$finish;
	end

endmodule
